// ===== rtl/core/hbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbtc_pkg
// Shared types and constants for the box against tile bitmap collision block.
// ----------------------------------------------------------------------------
package hbtc_pkg;

  localparam int EDGE_W    = 17;
  localparam int PIX_W     = 13;
  localparam int TILE_W    = 6;
  localparam int BYTE_W    = 8;
  localparam int ROW_BYTES = 8;
  localparam int MAP_ROWS  = 64;
  localparam int ROW_BITS  = BYTE_W * ROW_BYTES;

  localparam logic [TILE_W-1:0] TILE_MAX = TILE_W'(MAP_ROWS - 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic wr_byte;
    logic load_query;
    logic tile_calc;
    logic mask_load;
    logic scan_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic off_map;
    logic last_row;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/hitbox_tile_bitmap_collision.sv =====
// ----------------------------------------------------------------------------
// hitbox_tile_bitmap_collision
// A bitmap write request gives no result and leaves the block ready for another.
// A query steps through tile arithmetic, mask load, a scan of the R covered tile
// rows (1 to 33 for 8-bit sizes), one bitmap row read per cycle, and a drain; no
// request is taken meanwhile. An off-map box skips the mask load, scan and drain.
// The result waits in an output register; a new request is taken while it waits.
// After reset a clearing pass zeroes all 64 bitmap rows; no request is taken.
// ----------------------------------------------------------------------------
module hitbox_tile_bitmap_collision #(
  parameter int MAP_PIXEL_WIDTH  = 512,
  parameter int MAP_PIXEL_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic [7:0]         box_width,
  input  logic [7:0]         box_height,
  input  logic [5:0]         map_row,
  input  logic [2:0]         map_byte_col,
  input  logic [7:0]         map_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit
);

  hbtc_pkg::cmd_t    cmd;
  hbtc_pkg::status_t st;

  hbtc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode  (opcode),
    .st      (st),
    .cmd     (cmd)
  );

  hbtc_dp #(
    .MAP_PIXEL_WIDTH (MAP_PIXEL_WIDTH),
    .MAP_PIXEL_HEIGHT(MAP_PIXEL_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .center_x    (center_x),
    .center_y    (center_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .map_row     (map_row),
    .map_byte_col(map_byte_col),
    .map_byte    (map_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit)
  );

endmodule

// ===== rtl/core/hbtc_ram.sv =====
// ----------------------------------------------------------------------------
// hbtc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hbtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hbtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbtc_ctrl
// Controller state machine: clearing pass, request intake, row scan sequence
// and result hand-off.
// ----------------------------------------------------------------------------
module hbtc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  hbtc_pkg::status_t st,
  output hbtc_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_TILE  = 7'b0000100,
    S_MASK  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode == hbtc_pkg::OP_QUERY) begin
            cmd.load_query = 1'b1;
            state_next     = S_TILE;
          end else begin
            cmd.wr_byte = 1'b1;
          end
        end
      end
      S_TILE: begin
        cmd.tile_calc = 1'b1;
        state_next    = S_MASK;
      end
      S_MASK: begin
        if (st.off_map) begin
          state_next = S_DONE;
        end else begin
          cmd.mask_load = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        if (st.last_row) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/hbtc_dp.sv =====
// ----------------------------------------------------------------------------
// hbtc_dp
// Datapath: bitmap storage in eight byte-column RAMs, edge and tile
// arithmetic, column mask, row counter, hit accumulator and result register.
// ----------------------------------------------------------------------------
module hbtc_dp #(
  parameter int MAP_PIXEL_WIDTH  = 512,
  parameter int MAP_PIXEL_HEIGHT = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hbtc_pkg::cmd_t         cmd,
  output hbtc_pkg::status_t      st,
  input  logic signed [15:0]     center_x,
  input  logic signed [15:0]     center_y,
  input  logic [7:0]             box_width,
  input  logic [7:0]             box_height,
  input  logic [5:0]             map_row,
  input  logic [2:0]             map_byte_col,
  input  logic [7:0]             map_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit
);

  localparam int EW = hbtc_pkg::EDGE_W;
  localparam int TW = hbtc_pkg::TILE_W;
  localparam int RB = hbtc_pkg::ROW_BYTES;
  localparam int BW = hbtc_pkg::BYTE_W;
  localparam int NB = hbtc_pkg::ROW_BITS;
  localparam logic signed [EW-1:0] XLIM = EW'(MAP_PIXEL_WIDTH);
  localparam logic signed [EW-1:0] YLIM = EW'(MAP_PIXEL_HEIGHT);

  function automatic logic [TW-1:0] clamp_tile(input logic signed [EW-1:0] v,
                                                input logic signed [EW-1:0] lim);
    logic signed [EW-1:0] p;
    logic [hbtc_pkg::PIX_W-4:0] t;
    if (v < 0) begin
      p = '0;
    end else if (v >= lim) begin
      p = lim - EW'(1);
    end else begin
      p = v;
    end
    t = p[hbtc_pkg::PIX_W-1:3];
    return (t > (hbtc_pkg::PIX_W-3)'(hbtc_pkg::TILE_MAX)) ? hbtc_pkg::TILE_MAX
                                                           : t[TW-1:0];
  endfunction

  logic signed [EW-1:0] left, right, top, bottom;
  logic signed [EW-1:0] cx_ext, cy_ext, hw, hh;
  logic [TW-1:0]        tl, tr, tt, tb;
  logic                 off_map;
  logic [NB-1:0]        mask;
  logic [TW-1:0]        row;
  logic [TW-1:0]        clr_addr;
  logic                 data_valid;
  logic                 hit_acc;
  logic [NB-1:0]        row_bits;

  logic                 ram_we [RB];
  logic [TW-1:0]        ram_waddr;
  logic [BW-1:0]        ram_wdata;

  assign cx_ext = EW'(center_x);
  assign cy_ext = EW'(center_y);
  assign hw     = $signed(EW'(box_width[7:1]));
  assign hh     = $signed(EW'(box_height[7:1]));

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      left   <= cx_ext - hw;
      right  <= cx_ext + hw;
      top    <= cy_ext - hh;
      bottom <= cy_ext + hh;
    end
    if (cmd.tile_calc) begin
      off_map <= (left >= XLIM) || (right < 0) || (top >= YLIM) || (bottom < 0);
      tl      <= clamp_tile(left, XLIM);
      tr      <= clamp_tile(right, XLIM);
      tt      <= clamp_tile(top, YLIM);
      tb      <= clamp_tile(bottom, YLIM);
    end
    if (cmd.mask_load) begin
      mask <= ({NB{1'b1}} << tl) & ({NB{1'b1}} >> (hbtc_pkg::TILE_MAX - tr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      row        <= '0;
      data_valid <= 1'b0;
      hit_acc    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + TW'(1);
      end
      if (cmd.mask_load) begin
        row <= tt;
      end else if (cmd.scan_read) begin
        row <= row + TW'(1);
      end
      data_valid <= cmd.scan_read;
      if (cmd.load_query) begin
        hit_acc <= 1'b0;
      end else if (data_valid) begin
        hit_acc <= hit_acc | (|(row_bits & mask));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit <= hit_acc;
    end
  end

  always_comb begin
    ram_waddr = cmd.clear_step ? clr_addr : map_row;
    ram_wdata = cmd.clear_step ? '0 : map_byte;
    for (int b = 0; b < RB; b++) begin
      ram_we[b] = cmd.clear_step || (cmd.wr_byte && (map_byte_col == 3'(b)));
    end
  end

  for (genvar g = 0; g < RB; g++) begin : g_col
    hbtc_ram #(
      .WIDTH(BW),
      .DEPTH(hbtc_pkg::MAP_ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[g]),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(row),
      .rdata(row_bits[g*BW +: BW])
    );
  end

  assign st.clear_last = (clr_addr == hbtc_pkg::TILE_MAX);
  assign st.off_map    = off_map;
  assign st.last_row   = (row == tb);
  assign st.out_free   = !out_valid || !out_stall;

endmodule
